FILE: design/sweep_prune_box_overlap_filter_assert.svh
// Assertion macros used by the filter's top level.
`ifndef SWEEP_PRUNE_BOX_OVERLAP_FILTER_ASSERT_SVH
`define SWEEP_PRUNE_BOX_OVERLAP_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPBOF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPBOF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/spbof_pkg.sv
// Types and constants of the sweep-and-prune box overlap filter.
`timescale 1ns / 1ps
package spbof_pkg;

   localparam int COORD_BITS   = 32;
   localparam int PROXY_BITS   = 31;
   localparam int COUNT_BITS   = 20;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DAT_BITS = 32;
   localparam int AXIS_BITS    = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_QUERY_MIN_X = 3'd0,
      CSR_QUERY_MIN_Y = 3'd1,
      CSR_QUERY_MIN_Z = 3'd2,
      CSR_QUERY_MAX_X = 3'd3,
      CSR_QUERY_MAX_Y = 3'd4,
      CSR_QUERY_MAX_Z = 3'd5,
      CSR_SWEEP_AXIS  = 3'd6
   } csr_idx_type;

   typedef enum logic [AXIS_BITS-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] min_x;
      logic [COORD_BITS-1:0] min_y;
      logic [COORD_BITS-1:0] min_z;
      logic [COORD_BITS-1:0] max_x;
      logic [COORD_BITS-1:0] max_y;
      logic [COORD_BITS-1:0] max_z;
   } box_type;

   typedef struct packed {
      box_type               query;
      logic [AXIS_BITS-1:0]  axis;
   } query_type;

   typedef struct packed {
      box_type               box;
      logic [PROXY_BITS-1:0] proxy;
      logic                  last;
   } cand_type;

   typedef struct packed {
      logic overlap;     // all six interval tests pass
      logic past_sweep;  // candidate min on sweep axis beyond query max
   } test_type;

   typedef struct packed {
      logic                  stopped;
      logic [COUNT_BITS-1:0] count;
   } scan_state_type;

   typedef struct packed {
      logic                  hit;
      logic [PROXY_BITS-1:0] hit_proxy;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  scan_stopped;
      logic                  scan_done;
   } rsp_type;

endpackage

FILE: design/spbof_if.sv
// Channel interfaces: candidate input, result output, register write port.
`timescale 1ns / 1ps
interface spbof_req_if import spbof_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cand_min_x;
   logic [COORD_BITS-1:0] cand_min_y;
   logic [COORD_BITS-1:0] cand_min_z;
   logic [COORD_BITS-1:0] cand_max_x;
   logic [COORD_BITS-1:0] cand_max_y;
   logic [COORD_BITS-1:0] cand_max_z;
   logic [PROXY_BITS-1:0] cand_proxy;
   logic                  cand_last;

   modport source (output valid, cand_min_x, cand_min_y, cand_min_z,
                   cand_max_x, cand_max_y, cand_max_z, cand_proxy, cand_last,
                   input ready);
   modport sink   (input valid, cand_min_x, cand_min_y, cand_min_z,
                   cand_max_x, cand_max_y, cand_max_z, cand_proxy, cand_last,
                   output ready);
endinterface

interface spbof_rsp_if import spbof_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [PROXY_BITS-1:0] hit_proxy;
   logic [COUNT_BITS-1:0] hit_count;
   logic                  scan_stopped;
   logic                  scan_done;

   modport source (output valid, hit, hit_proxy, hit_count, scan_stopped, scan_done,
                   input ready);
   modport sink   (input valid, hit, hit_proxy, hit_count, scan_stopped, scan_done,
                   output ready);
endinterface

interface spbof_csr_if import spbof_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CSR_DAT_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/sweep_prune_box_overlap_filter.sv
// Top level of the sweep-and-prune box overlap filter.
`timescale 1ns / 1ps
// Streams candidate boxes (signed Q16.16, sorted by minimum on the sweep axis)
// against a query box held in seven registers written over csr_ch. Every
// accepted candidate yields exactly one result beat: hit, the echoed proxy id,
// the running hit count (saturating at all ones), the stopped flag and a done
// flag equal to cand_last. The scan stops once a candidate's sweep-axis minimum
// exceeds the query maximum on that axis; that candidate and all later ones in
// the scan miss. After the last candidate's result the count and flag clear.
// Rate: one candidate per cycle while rsp_ch takes results, else req_ch stalls.
// Path: input register, then the six compares and the counter update into the
// result register. Register writes only while the block is idle.
module sweep_prune_box_overlap_filter import spbof_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   spbof_req_if.sink     req_ch,
   spbof_rsp_if.source   rsp_ch,
   spbof_csr_if.sink     csr_ch
);

`include "sweep_prune_box_overlap_filter_assert.svh"

   query_type       query;
   test_type        test;
   scan_state_type  state;
   scan_state_type  state_now;
   logic            hit;

   // input stage
   logic            stg_valid_ff;
   logic            stg_valid_in;
   cand_type        stg_ff;
   logic            stg_load;

   // result stage
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_ff;
   logic            out_free;   // result register can take a beat this cycle
   logic            advance;

   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign advance      = stg_valid_ff & out_free;
   assign req_ch.ready = ~stg_valid_ff | out_free;
   assign stg_load     = req_ch.valid & req_ch.ready;

   assign stg_valid_in = stg_load | (stg_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (stg_load) begin
         stg_ff.box.min_x <= req_ch.cand_min_x;
         stg_ff.box.min_y <= req_ch.cand_min_y;
         stg_ff.box.min_z <= req_ch.cand_min_z;
         stg_ff.box.max_x <= req_ch.cand_max_x;
         stg_ff.box.max_y <= req_ch.cand_max_y;
         stg_ff.box.max_z <= req_ch.cand_max_z;
         stg_ff.proxy     <= req_ch.cand_proxy;
         stg_ff.last      <= req_ch.cand_last;
      end
      if (advance) begin
         rsp_ff.hit          <= hit;
         rsp_ff.hit_proxy    <= stg_ff.proxy;
         rsp_ff.hit_count    <= state_now.count;
         rsp_ff.scan_stopped <= state_now.stopped;
         rsp_ff.scan_done    <= stg_ff.last;
      end
   end

   spbof_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .query  (query)
   );

   spbof_box_test u_test (
      .cand  (stg_ff.box),
      .query (query),
      .test  (test)
   );

   spbof_scan_ctrl u_scan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .last      (stg_ff.last),
      .test      (test),
      .state     (state),
      .hit       (hit),
      .state_now (state_now)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hit          = rsp_ff.hit;
   assign rsp_ch.hit_proxy    = rsp_ff.hit_proxy;
   assign rsp_ch.hit_count    = rsp_ff.hit_count;
   assign rsp_ch.scan_stopped = rsp_ff.scan_stopped;
   assign rsp_ch.scan_done    = rsp_ff.scan_done;

   // a hit is never reported once the scan has stopped
   `SPBOF_ASSERT_NOW(a_hit_not_stopped, clock, reset,
      rsp_valid_ff && rsp_ff.hit, !rsp_ff.scan_stopped, "hit on a stopped scan")
   // the last candidate leaves a fresh scan behind
   `SPBOF_ASSERT_NEXT(a_last_clears, clock, reset,
      advance && stg_ff.last, state.count == '0 && !state.stopped,
      "scan state not cleared after last beat")
   // stopped flag only falls at the end of a scan
   `SPBOF_ASSERT_NEXT(a_stop_sticky, clock, reset,
      state.stopped && !(advance && stg_ff.last), state.stopped,
      "stopped flag dropped mid-scan")
   // an empty input stage always takes a beat
   `SPBOF_ASSERT_NOW(a_stage_ready, clock, reset,
      !stg_valid_ff, req_ch.ready, "input stage empty but not ready")

endmodule

FILE: design/spbof_csr_regs.sv
// Query box and sweep axis registers behind the write port.
`timescale 1ns / 1ps
module spbof_csr_regs import spbof_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   spbof_csr_if.sink  csr_ch,
   output query_type  query
);

   query_type query_ff;
   query_type query_in;

   assign csr_ch.ready = 1'b1;
   assign query        = query_ff;

   always_comb begin
      query_in = query_ff;
      if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_QUERY_MIN_X: query_in.query.min_x = csr_ch.data[COORD_BITS-1:0];
            CSR_QUERY_MIN_Y: query_in.query.min_y = csr_ch.data[COORD_BITS-1:0];
            CSR_QUERY_MIN_Z: query_in.query.min_z = csr_ch.data[COORD_BITS-1:0];
            CSR_QUERY_MAX_X: query_in.query.max_x = csr_ch.data[COORD_BITS-1:0];
            CSR_QUERY_MAX_Y: query_in.query.max_y = csr_ch.data[COORD_BITS-1:0];
            CSR_QUERY_MAX_Z: query_in.query.max_z = csr_ch.data[COORD_BITS-1:0];
            CSR_SWEEP_AXIS:  query_in.axis        = csr_ch.data[AXIS_BITS-1:0];
            default:         query_in             = query_ff;  // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff <= '0;
      end else begin
         query_ff <= query_in;
      end
   end

endmodule

FILE: design/spbof_box_test.sv
// Six closed-interval tests plus the sweep-axis stop test.
`timescale 1ns / 1ps
module spbof_box_test import spbof_pkg::*; (
   input  box_type    cand,
   input  query_type  query,
   output test_type   test
);

   logic                  ok_x;
   logic                  ok_y;
   logic                  ok_z;
   logic [COORD_BITS-1:0] sweep_min;
   logic [COORD_BITS-1:0] sweep_max;

   always_comb begin
      ok_x = ($signed(query.query.min_x) <= $signed(cand.max_x)) &&
             ($signed(cand.min_x) <= $signed(query.query.max_x));
      ok_y = ($signed(query.query.min_y) <= $signed(cand.max_y)) &&
             ($signed(cand.min_y) <= $signed(query.query.max_y));
      ok_z = ($signed(query.query.min_z) <= $signed(cand.max_z)) &&
             ($signed(cand.min_z) <= $signed(query.query.max_z));

      // axis code 3 falls back to z
      unique case (axis_type'(query.axis))
         AXIS_X: begin
            sweep_min = cand.min_x;
            sweep_max = query.query.max_x;
         end
         AXIS_Y: begin
            sweep_min = cand.min_y;
            sweep_max = query.query.max_y;
         end
         default: begin
            sweep_min = cand.min_z;
            sweep_max = query.query.max_z;
         end
      endcase

      test.overlap    = ok_x && ok_y && ok_z;
      test.past_sweep = $signed(sweep_min) > $signed(sweep_max);
   end

endmodule

FILE: design/spbof_scan_ctrl.sv
// Scan state: stopped flag and saturating hit counter, cleared after the last beat.
`timescale 1ns / 1ps
module spbof_scan_ctrl import spbof_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,   // stage item moves to the result register
   input  logic            last,
   input  test_type        test,
   output scan_state_type  state,
   output logic            hit,
   output scan_state_type  state_now  // state as seen by this item's result
);

   scan_state_type state_ff;
   scan_state_type state_in;

   assign state = state_ff;

   always_comb begin
      state_now.stopped = state_ff.stopped | test.past_sweep;
      hit               = test.overlap & ~state_now.stopped;
      state_now.count   = (hit && (state_ff.count != COUNT_MAX)) ?
                          state_ff.count + 1'b1 : state_ff.count;

      state_in = state_ff;
      if (advance) begin
         state_in = last ? '0 : state_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: verif/tb_sweep_prune_box_overlap_filter.sv
// Testbench for the box overlap filter: random-timed candidate streams checked beat by beat.
`timescale 1ns / 1ps
module tb_sweep_prune_box_overlap_filter;
   import spbof_pkg::*;

   // ---------------------------------------------------------------------------
   // Constants
   // ---------------------------------------------------------------------------
   localparam int CLK_PERIOD = 10;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1250;
   localparam int LONG_SCAN_ITEMS = 48;
   localparam longint TIMEOUT_NS = 64'd3_000_000;

   // Register index with no register behind it; writes there must be dropped.
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_UNUSED = 3'd7;

   localparam logic [COORD_BITS-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [COORD_BITS-1:0] COORD_MAX = 32'h7fff_ffff;
   localparam logic [COORD_BITS-1:0] ONE = 32'h0001_0000;      // 1.0 in Q16.16
   localparam logic [COORD_BITS-1:0] NEG_ONE = 32'hffff_0000;  // -1.0
   localparam logic [PROXY_BITS-1:0] PROXY_ALL = '1;

   // Per-axis coordinates, index 0 = x, 1 = y, 2 = z.
   typedef logic [2:0][COORD_BITS-1:0] coord3_type;

   // One queued candidate plus the idle cycles to insert before it.
   typedef struct {
      cand_type    cand;
      int unsigned gap;
   } cand_beat_type;

   // ---------------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(CLK_PERIOD / 2) clock = ~clock;

   spbof_req_if req_bus ();
   spbof_rsp_if rsp_bus ();
   spbof_csr_if csr_bus ();

   sweep_prune_box_overlap_filter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // ---------------------------------------------------------------------------
   // Shadow of the filter: query registers and scan state
   // ---------------------------------------------------------------------------
   logic [COORD_BITS-1:0] query_lo [3];
   logic [COORD_BITS-1:0] query_hi [3];
   logic [AXIS_BITS-1:0]  sweep_sel;
   logic                  scan_halted;
   logic [COUNT_BITS-1:0] scan_hits;

   cand_beat_type cand_backlog [$];  // candidates not yet accepted by the filter
   rsp_type    pending_reports [$];  // predicted result beats, oldest first

   // Handshake bookkeeping between the posedge monitor and the negedge drivers.
   bit          req_taken = 1'b0;
   bit          rsp_taken = 1'b0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          req_gap_armed = 1'b0;
   int unsigned req_gap_left = 0;
   int unsigned rsp_stall_left = 0;

   // Run statistics.
   int n_items = 0;
   int n_random = 0;
   int n_hits = 0;
   int n_stops = 0;
   int n_scans = 0;
   int n_csr = 0;
   int n_errors = 0;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------
   function automatic bit coord_le(logic [COORD_BITS-1:0] a, logic [COORD_BITS-1:0] b);
      return $signed(a) <= $signed(b);
   endfunction

   // An axis code of 3 selects z, same as 2.
   function automatic int sweep_index();
      return (sweep_sel > AXIS_Z) ? int'(AXIS_Z) : int'(sweep_sel);
   endfunction

   // Advances the scan state by one candidate and returns its result beat.
   function automatic rsp_type classify_candidate(cand_type c);
      coord3_type lo;
      coord3_type hi;
      bit      overlap;
      int      ax;
      rsp_type r;
      lo = {c.box.min_z, c.box.min_y, c.box.min_x};
      hi = {c.box.max_z, c.box.max_y, c.box.max_x};
      overlap = 1'b1;
      // closed intervals on all three axes
      for (int k = 0; k < 3; k++) begin
         if (!coord_le(query_lo[k], hi[k]) || !coord_le(lo[k], query_hi[k])) overlap = 1'b0;
      end
      // sweep test: once past the query max on the sort axis, the scan is over
      ax = sweep_index();
      if (!coord_le(lo[ax], query_hi[ax])) scan_halted = 1'b1;
      r.hit = overlap && !scan_halted;
      if (r.hit && scan_hits != COUNT_MAX) scan_hits++;
      r.hit_proxy = c.proxy;
      r.hit_count = scan_hits;
      r.scan_stopped = scan_halted;
      r.scan_done = c.last;
      // last beat reports first, then the scan state clears
      if (c.last) begin
         scan_halted = 1'b0;
         scan_hits = '0;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         n_errors++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : beat_monitor
      rsp_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pending_reports.push_back(classify_candidate(cand_backlog[0].cand));
            cand_backlog.pop_front();
            req_taken = 1'b1;
            n_items++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_taken = 1'b1;
            if (pending_reports.size() == 0) begin
               $error("result beat with none outstanding, proxy %0h", rsp_bus.hit_proxy);
               n_errors++;
            end else begin
               want = pending_reports.pop_front();
               check_field("hit", want.hit, rsp_bus.hit);
               check_field("hit_proxy", want.hit_proxy, rsp_bus.hit_proxy);
               check_field("hit_count", want.hit_count, rsp_bus.hit_count);
               check_field("scan_stopped", want.scan_stopped, rsp_bus.scan_stopped);
               check_field("scan_done", want.scan_done, rsp_bus.scan_done);
               n_hits += want.hit;
               n_stops += want.scan_stopped;
               n_scans += want.scan_done;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Candidate driver: changes inputs at the falling edge, honors per-beat gaps
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : cand_driver
      logic drive;
      drive = 1'b0;
      if (!reset) begin
         if (req_bus.valid && !req_taken) begin
            drive = 1'b1;  // beat still waiting on ready
         end else if (cand_backlog.size() != 0) begin
            if (!req_gap_armed) begin
               req_gap_left = cand_backlog[0].gap;
               req_gap_armed = 1'b1;
            end
            if (req_gap_left == 0) begin
               drive = 1'b1;
               req_gap_armed = 1'b0;
               req_bus.cand_min_x = cand_backlog[0].cand.box.min_x;
               req_bus.cand_min_y = cand_backlog[0].cand.box.min_y;
               req_bus.cand_min_z = cand_backlog[0].cand.box.min_z;
               req_bus.cand_max_x = cand_backlog[0].cand.box.max_x;
               req_bus.cand_max_y = cand_backlog[0].cand.box.max_y;
               req_bus.cand_max_z = cand_backlog[0].cand.box.max_z;
               req_bus.cand_proxy = cand_backlog[0].cand.proxy;
               req_bus.cand_last = cand_backlog[0].cand.last;
            end else begin
               req_gap_left--;
            end
         end
      end
      req_taken = 1'b0;
      req_bus.valid = drive;  // single write per edge, no glitch between beats
   end

   // Result receiver: a fresh stall length after every accepted beat.
   always @(negedge clock) begin : result_receiver
      if (rsp_taken) begin
         rsp_stall_left = rsp_idle_on ? $urandom_range(0, 9) : 0;
         rsp_taken = 1'b0;
      end
      if (rsp_stall_left != 0) begin
         rsp_bus.ready = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic longint rand_upto(longint range);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return longint'(r % (range + 1));
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
      if (v < longint'($signed(COORD_MIN))) return COORD_MIN;
      if (v > longint'($signed(COORD_MAX))) return COORD_MAX;
      return COORD_BITS'(v);
   endfunction

   // Width of a query interval, never below 64 LSBs so margins stay useful.
   function automatic longint axis_span(logic [COORD_BITS-1:0] qa, logic [COORD_BITS-1:0] qb);
      longint w;
      w = longint'($signed(qb)) - longint'($signed(qa));
      if (w < 0) w = -w;
      return (w < 64) ? 64 : w;
   endfunction

   // Coordinate around the query interval, with some far-off and extreme values.
   function automatic logic [COORD_BITS-1:0] coord_near(logic [COORD_BITS-1:0] qa,
                                                        logic [COORD_BITS-1:0] qb);
      longint a;
      longint w;
      a = coord_le(qa, qb) ? longint'($signed(qa)) : longint'($signed(qb));
      w = axis_span(qa, qb);
      case ($urandom_range(0, 15))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         default: return clamp_coord(a - w / 2 + rand_upto(2 * w));
      endcase
   endfunction

   // Box maximum from its minimum; sometimes degenerate or inverted.
   function automatic logic [COORD_BITS-1:0] coord_extend(logic [COORD_BITS-1:0] base,
                                                          logic [COORD_BITS-1:0] qa,
                                                          logic [COORD_BITS-1:0] qb);
      longint w;
      w = axis_span(qa, qb);
      case ($urandom_range(0, 15))
         0: return clamp_coord(longint'($signed(base)) - 1 - rand_upto(w));
         1: return base;
         2: return $urandom;
         default: return clamp_coord(longint'($signed(base)) + rand_upto(w));
      endcase
   endfunction

   function automatic logic [PROXY_BITS-1:0] rand_proxy();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return PROXY_ALL;
         default: return PROXY_BITS'($urandom);
      endcase
   endfunction

   // Random query interval on one axis: ordinary, full, point, inverted, or at a rail.
   function automatic void pick_range(output logic [COORD_BITS-1:0] lo,
                                      output logic [COORD_BITS-1:0] hi);
      longint c;
      longint half;
      c = longint'($signed($urandom)) >>> $urandom_range(0, 14);
      half = rand_upto(64'd1 << $urandom_range(4, 30));
      case ($urandom_range(0, 9))
         0: begin
            lo = COORD_MIN;
            hi = COORD_MAX;
         end
         1: begin
            lo = clamp_coord(c);
            hi = lo;
         end
         2: begin
            lo = clamp_coord(c + half);
            hi = clamp_coord(c - half);
         end
         3: begin
            lo = clamp_coord(longint'($signed(COORD_MAX)) - half);
            hi = COORD_MAX;
         end
         4: begin
            lo = COORD_MIN;
            hi = clamp_coord(longint'($signed(COORD_MIN)) + half);
         end
         default: begin
            lo = clamp_coord(c - half);
            hi = clamp_coord(c + half);
         end
      endcase
   endfunction

   // One register write; the shadow copy follows at the accepting edge.
   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DAT_BITS-1:0] word);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = word;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_QUERY_MIN_X, CSR_QUERY_MIN_Y, CSR_QUERY_MIN_Z:
            query_lo[idx - CSR_QUERY_MIN_X] = word;
         CSR_QUERY_MAX_X, CSR_QUERY_MAX_Y, CSR_QUERY_MAX_Z:
            query_hi[idx - CSR_QUERY_MAX_X] = word;
         CSR_SWEEP_AXIS:
            sweep_sel = word[AXIS_BITS-1:0];
         default: ;  // no register there
      endcase
      n_csr++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Writes all seven registers, in index order or shuffled.
   task automatic set_query(coord3_type lo, coord3_type hi, logic [CSR_DAT_BITS-1:0] axis_word,
                            bit shuffled);
      csr_idx_type           order [$];
      logic [CSR_DAT_BITS-1:0] word;
      order = {CSR_QUERY_MIN_X, CSR_QUERY_MIN_Y, CSR_QUERY_MIN_Z,
               CSR_QUERY_MAX_X, CSR_QUERY_MAX_Y, CSR_QUERY_MAX_Z, CSR_SWEEP_AXIS};
      if (shuffled) order.shuffle();
      foreach (order[i]) begin
         case (order[i])
            CSR_SWEEP_AXIS: word = axis_word;
            CSR_QUERY_MAX_X, CSR_QUERY_MAX_Y, CSR_QUERY_MAX_Z:
               word = hi[order[i] - CSR_QUERY_MAX_X];
            default: word = lo[order[i] - CSR_QUERY_MIN_X];
         endcase
         csr_write(order[i], word);
      end
   endtask

   task automatic add_cand(coord3_type lo, coord3_type hi, logic [PROXY_BITS-1:0] proxy,
                           logic last);
      cand_beat_type b;
      b.cand.box.min_x = lo[0];
      b.cand.box.min_y = lo[1];
      b.cand.box.min_z = lo[2];
      b.cand.box.max_x = hi[0];
      b.cand.box.max_y = hi[1];
      b.cand.box.max_z = hi[2];
      b.cand.proxy = proxy;
      b.cand.last = last;
      b.gap = req_idle_on ? $urandom_range(0, 9) : 0;
      cand_backlog.push_back(b);
   endtask

   // One scan of n candidates; sorted on the sweep axis unless a broken stream is wanted.
   task automatic push_scan(int n, bit sorted);
      longint  keys [$];
      coord3_type lo;
      coord3_type hi;
      int      ax;
      ax = sweep_index();
      for (int i = 0; i < n; i++)
         keys.push_back(longint'($signed(coord_near(query_lo[ax], query_hi[ax]))));
      if (sorted) keys.sort();
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < 3; k++) begin
            lo[k] = (k == ax) ? COORD_BITS'(keys[i]) : coord_near(query_lo[k], query_hi[k]);
            hi[k] = coord_extend(lo[k], query_lo[k], query_hi[k]);
         end
         add_cand(lo, hi, rand_proxy(), i == n - 1);
      end
   endtask

   // Sender holds off until every result is back; then the filter is idle.
   task automatic drain();
      while (cand_backlog.size() != 0 || pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);  // margin after the last result beat
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      coord3_type              lo;
      coord3_type              hi;
      coord3_type              qlo;
      coord3_type              qhi;
      logic [CSR_DAT_BITS-1:0] axis_word;
      int                      n;

      // known values on every input from time zero
      req_bus.valid = 1'b0;
      req_bus.cand_min_x = '0;
      req_bus.cand_min_y = '0;
      req_bus.cand_min_z = '0;
      req_bus.cand_max_x = '0;
      req_bus.cand_max_y = '0;
      req_bus.cand_max_z = '0;
      req_bus.cand_proxy = '0;
      req_bus.cand_last = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_QUERY_MIN_X;
      csr_bus.data = '0;

      // shadow starts at the reset values
      query_lo = '{default: '0};
      query_hi = '{default: '0};
      sweep_sel = AXIS_X;
      scan_halted = 1'b0;
      scan_hits = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      qlo = {3{NEG_ONE}};
      qhi = {3{ONE}};

      // reset query is a point at the origin; a unit box around it hits
      add_cand(qlo, qhi, 31'd1, 1'b1);
      drain();

      // --- unit query, sweep on x ---
      set_query(qlo, qhi, 32'(AXIS_X), 1'b0);
      add_cand(qlo, qhi, 31'd2, 1'b0);               // identical box
      lo = qlo; hi = qhi;
      lo[0] = 32'hfffd_0000; hi[0] = NEG_ONE;        // touches query min on x
      add_cand(lo, hi, 31'd3, 1'b0);
      lo = qlo; hi = qhi;
      hi[1] = NEG_ONE - 1;                           // one LSB short on y
      add_cand(lo, hi, 31'd4, 1'b0);
      lo = qlo; hi = qhi;
      lo[2] = ONE + 1; hi[2] = 32'h0003_0000;        // past max on z, not the sweep axis
      add_cand(lo, hi, 31'd5, 1'b0);
      add_cand({3{COORD_MAX}}, {3{COORD_MIN}}, 31'd6, 1'b0);  // inverted, rail to rail
      add_cand({3{COORD_MIN}}, {3{COORD_MAX}}, 31'd7, 1'b0);  // covers all space
      lo = qlo; hi = qhi;
      lo[0] = ONE; hi[0] = 32'h0002_0000;            // sweep min equal to query max, not beyond it
      add_cand(lo, hi, 31'd8, 1'b0);
      lo[0] = ONE + 1;                               // one LSB beyond query max on the sweep axis
      add_cand(lo, hi, 31'd9, 1'b0);
      add_cand(qlo, qhi, 31'd10, 1'b0);              // overlapping, but after the stop
      add_cand(qlo, qhi, 31'd11, 1'b1);              // last clears stop and count
      add_cand(qlo, qhi, PROXY_ALL, 1'b1);           // fresh one-beat scan
      drain();

      // --- sweep axis code 3 acts as z; stray write to the unused index ---
      csr_write(CSR_SWEEP_AXIS, 32'd3);
      csr_write(CSR_IDX_UNUSED, $urandom);
      lo = qlo; hi = qhi;
      lo[0] = 32'h0002_0000; hi[0] = 32'h0003_0000;  // beyond on x, which no longer stops
      add_cand(lo, hi, 31'd12, 1'b0);
      add_cand(qlo, qhi, 31'd13, 1'b0);
      lo = qlo; hi = qhi;
      lo[2] = ONE + 1; hi[2] = 32'h0003_0000;        // beyond on z: stops
      add_cand(lo, hi, 31'd14, 1'b0);
      add_cand(qlo, qhi, 31'd15, 1'b1);
      drain();

      // --- query spans the whole range, sweep y via a word with junk upper bits ---
      set_query({3{COORD_MIN}}, {3{COORD_MAX}}, 32'hffff_fffd, 1'b1);
      add_cand({3{COORD_MIN}}, {3{COORD_MIN}}, 31'd16, 1'b0);
      add_cand({3{COORD_MAX}}, {3{COORD_MAX}}, 31'd0, 1'b0);
      add_cand({3{COORD_MAX}}, {3{COORD_MIN}}, 31'd18, 1'b1);
      drain();

      // --- point queries pinned at each rail ---
      set_query({3{COORD_MAX}}, {3{COORD_MAX}}, 32'(AXIS_Z), 1'b1);
      add_cand({3{COORD_MAX}}, {3{COORD_MAX}}, 31'd19, 1'b1);
      drain();
      set_query({3{COORD_MIN}}, {3{COORD_MIN}}, 32'(AXIS_Y), 1'b0);
      add_cand({3{COORD_MIN}}, {3{COORD_MAX}}, 31'd20, 1'b0);
      lo = {3{COORD_MIN}};
      lo[1] = COORD_MIN + 1;
      add_cand(lo, {3{COORD_MAX}}, 31'd21, 1'b0);
      add_cand({3{COORD_MIN}}, {3{COORD_MAX}}, 31'd22, 1'b1);
      drain();

      // --- long scan where every beat hits, back to back on both sides ---
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_query({3{COORD_MIN}}, {3{COORD_MAX}}, 32'(AXIS_X), 1'b0);
      n = LONG_SCAN_ITEMS;
      for (int i = 0; i < n; i++) begin
         add_cand({3{COORD_MIN}}, {3{COORD_MAX}}, i[PROXY_BITS-1:0], i == n - 1);
      end
      drain();

      // --- random phases: new query each time, mostly sorted scans ---
      while (n_random < RANDOM_ITEMS) begin
         for (int k = 0; k < 3; k++) pick_range(lo[k], hi[k]);
         axis_word = $urandom_range(0, 3);
         if ($urandom_range(0, 1)) axis_word |= $urandom & ~32'd3;
         if ($urandom_range(0, 5) == 0) csr_write(CSR_IDX_UNUSED, $urandom);
         set_query(lo, hi, axis_word, 1'b1);
         // some phases run with no idling on one or both sides
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 6)) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 28);
            push_scan(n, $urandom_range(0, 4) != 0);
            n_random += n;
         end
         drain();
      end

      $display("covered %0d candidates (%0d random) in %0d scans: %0d hits, %0d stopped beats",
               n_items, n_random, n_scans, n_hits, n_stops);
      $display("%0d register writes: reset, unit, full-range, rail, long-scan, random queries",
               n_csr);
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard stop in case a handshake hangs.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: sweep_prune_box_overlap_filter.f
+incdir+design
design/spbof_pkg.sv
design/spbof_if.sv
design/spbof_csr_regs.sv
design/spbof_box_test.sv
design/spbof_scan_ctrl.sv
design/sweep_prune_box_overlap_filter.sv
verif/tb_sweep_prune_box_overlap_filter.sv
